FILE: hw/rtl/speed_profile_interpolator_macros.svh
// ---------------------------------------------------------------------------
// Speed profile interpolator assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SPEED_PROFILE_INTERPOLATOR_MACROS_SVH
`define SPEED_PROFILE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication.
`define SPI_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("spi: same-cycle check failed");

// Next-cycle implication.
`define SPI_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("spi: next-cycle check failed");

`endif

FILE: hw/rtl/spi_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Speed profile interpolator package
// Shared types, codes and the saturation helper.
// ---------------------------------------------------------------------------
package spi_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int DIV_STEPS      = 32;
  localparam int STEP_W         = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_APPEND       = 3'd0,
    OP_DIST_BY_TIME = 3'd1,
    OP_VEL_BY_DIST  = 3'd2,
    OP_ACC_BY_DIST  = 3'd3,
    OP_TIME_BY_DIST = 3'd4,
    OP_CLEAR        = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_DONE
  } ctl_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_FIN
  } md_state_t;

  typedef struct packed {
    logic               vld;
    logic               done;
    logic               interp;
    logic [2:0]         op;
    logic signed [31:0] q;
    logic signed [31:0] k0;
    logic signed [31:0] y0;
    logic signed [31:0] k1;
    logic signed [31:0] y1;
  } tok_t;

  typedef struct packed {
    logic               en;
    logic signed [31:0] distance;
    logic signed [31:0] tm;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
  } wr_t;

  // Returns the saturation flag above the 32-bit saturated value.
  function automatic logic [32:0] sat32(input logic signed [33:0] v);
    logic [32:0] r;
    if (v > 34'sd2147483647) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -34'sd2147483648) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/spi_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Speed profile interpolator input channel
// Valid/ready channel carrying one command with its point and query key.
// ---------------------------------------------------------------------------
interface spi_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] point_distance;
  logic signed [31:0] point_time;
  logic signed [31:0] point_velocity;
  logic signed [31:0] point_accel;
  logic signed [31:0] query_key;

  modport source (
    output valid, opcode, point_distance, point_time, point_velocity, point_accel,
    output query_key,
    input  ready
  );
  modport sink (
    input  valid, opcode, point_distance, point_time, point_velocity, point_accel,
    input  query_key,
    output ready
  );
endinterface

FILE: hw/rtl/spi_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Speed profile interpolator result channel
// Valid/ready channel carrying one result with the profile summary.
// ---------------------------------------------------------------------------
interface spi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  logic signed [31:0] total_time;
  logic signed [31:0] total_length;
  logic [6:0]         point_count;

  modport source (
    output valid, value, status, total_time, total_length, point_count,
    input  ready
  );
  modport sink (
    input  valid, value, status, total_time, total_length, point_count,
    output ready
  );
endinterface

FILE: hw/rtl/spi_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Profile point cell
// Holds one profile point and advances the search token by one place.
// ---------------------------------------------------------------------------
module spi_cell
  import spi_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int IDX        = 0,
  localparam int IDX_W     = $clog2(MAX_POINTS),
  localparam int CNT_W     = $clog2(MAX_POINTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [CNT_W-1:0] count,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic signed [31:0] dist_r;
  logic signed [31:0] tm_r;
  logic signed [31:0] vel_r;
  logic signed [31:0] acc_r;
  tok_t               tok_r;
  tok_t               tok_nxt;
  logic signed [31:0] key;
  logic signed [31:0] val;
  logic               active;

  always_ff @(posedge clk) begin
    if (wr.en && (wr_idx == IDX_W'(IDX))) begin
      dist_r <= wr.distance;
      tm_r   <= wr.tm;
      vel_r  <= wr.vel;
      acc_r  <= wr.acc;
    end
  end

  always_comb begin
    key     = dist_r;
    val     = tm_r;
    active  = count > CNT_W'(IDX);
    tok_nxt = tok_i;
    unique case (tok_i.op)
      OP_DIST_BY_TIME: begin
        key = tm_r;
        val = dist_r;
      end
      OP_VEL_BY_DIST: begin
        val = vel_r;
      end
      OP_ACC_BY_DIST: begin
        val = acc_r;
      end
      default: begin
        val = tm_r;
      end
    endcase
    if (tok_i.vld && !tok_i.done && active) begin
      if (key >= tok_i.q) begin
        tok_nxt.done = 1'b1;
        if (IDX == 0) begin
          tok_nxt.y0 = val;
        end else begin
          tok_nxt.interp = 1'b1;
          tok_nxt.k1     = key;
          tok_nxt.y1     = val;
        end
      end else begin
        tok_nxt.k0 = key;
        tok_nxt.y0 = val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: hw/rtl/spi_muldiv.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Interpolation step unit
// Computes y0 + trunc((y1 - y0) * (q - k0) / (k1 - k0)) with one multiply and
// a restoring division of one quotient bit per cycle, then saturates.
// ---------------------------------------------------------------------------
module spi_muldiv
  import spi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] y0,
  input  logic signed [31:0] k0,
  input  logic signed [31:0] y1,
  input  logic signed [31:0] k1,
  input  logic signed [31:0] q,
  output logic               done,
  output logic signed [31:0] value,
  output logic               sat
);

  md_state_t          st_r, st_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic signed [31:0] y0_r, y0_nxt;
  logic               neg_r, neg_nxt;
  logic [31:0]        mag_r, mag_nxt;
  logic [31:0]        n_r, n_nxt;
  logic [31:0]        d_r, d_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [31:0]        quo_r, quo_nxt;
  logic signed [32:0] dy;
  logic signed [32:0] dy_abs;
  logic [32:0]        n_full;
  logic [32:0]        d_full;
  logic [63:0]        prod;
  logic [32:0]        rem2;
  logic [32:0]        rem_sub;
  logic signed [33:0] sum;
  logic [32:0]        sat_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= MD_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    y0_r  <= y0_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    y0_nxt  = y0_r;
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    n_nxt   = n_r;
    d_nxt   = d_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    done    = 1'b0;
    dy      = {y1[31], y1} - {y0[31], y0};
    dy_abs  = dy[32] ? -dy : dy;
    n_full  = {q[31], q} - {k0[31], k0};
    d_full  = {k1[31], k1} - {k0[31], k0};
    prod    = mag_r * n_r;
    rem2    = {rem_r, quo_r[31]};
    rem_sub = rem2 - {1'b0, d_r};
    sum     = neg_r ? ({{2{y0_r[31]}}, y0_r} - {2'b00, quo_r})
                    : ({{2{y0_r[31]}}, y0_r} + {2'b00, quo_r});
    sat_res = sat32(sum);
    value   = sat_res[31:0];
    sat     = sat_res[32];
    unique case (st_r)
      MD_IDLE: begin
        if (start) begin
          y0_nxt  = y0;
          neg_nxt = dy[32];
          mag_nxt = dy_abs[31:0];
          n_nxt   = n_full[31:0];
          d_nxt   = d_full[31:0];
          st_nxt  = MD_MUL;
        end
      end
      MD_MUL: begin
        rem_nxt = prod[63:32];
        quo_nxt = prod[31:0];
        cnt_nxt = '0;
        st_nxt  = MD_DIV;
      end
      MD_DIV: begin
        if (rem2 >= {1'b0, d_r}) begin
          rem_nxt = rem_sub[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = rem2[31:0];
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          st_nxt = MD_FIN;
        end
      end
      MD_FIN: begin
        done   = 1'b1;
        st_nxt = MD_IDLE;
      end
      default: begin
        st_nxt = MD_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/speed_profile_interpolator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Speed profile interpolator
// Stores profile points in a row of cells and answers interpolated lookups.
// ---------------------------------------------------------------------------
// Usage: commands arrive on in_ch as valid/ready transfers; each gives exactly
// one result transfer on out_ch. Append stores a point (dropped with a full
// status when the table holds MAX_POINTS points), clear empties the profile,
// and the four queries look up distance by time or velocity, acceleration or
// time by distance. Every result carries total time, total length and count.
// Append, clear, unused codes and queries on an empty table load their result
// straight into the output register. A query sends a search token down the
// chain of point cells, one cell per cycle; a clamped answer is then loaded
// into the output register, while an interpolated one first passes through
// the multiply and the 32-step restoring division.
// One command is in flight at a time; the next is taken once the result has
// been loaded into the output register, and a command is taken while that
// register still waits only if the sink takes the waiting result at once.
// A stalled sink holds the result and blocks the next transfer.
// Reset empties the profile and drops any result not yet transferred.
// ---------------------------------------------------------------------------
`include "speed_profile_interpolator_macros.svh"

module speed_profile_interpolator
  import spi_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic clk,
  input logic rst_n,
  spi_in_if.sink    in_ch,
  spi_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  ctl_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic signed [31:0] first_t_r, first_t_nxt;
  logic signed [31:0] first_d_r, first_d_nxt;
  logic signed [31:0] last_t_r, last_t_nxt;
  logic signed [31:0] last_d_r, last_d_nxt;
  tok_t               launch_r, launch_nxt;
  logic signed [31:0] res_val_r, res_val_nxt;
  logic               res_sat_r, res_sat_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic signed [31:0] value_r, value_nxt;
  status_t            status_r, status_nxt;
  logic signed [31:0] tt_r, tt_nxt;
  logic signed [31:0] tl_r, tl_nxt;
  logic [6:0]         pc_r, pc_nxt;
  logic               accept;
  logic               slot_free;
  logic               load_out;
  logic [32:0]        tt_sat;
  logic [32:0]        tl_sat;
  wr_t                wr;
  logic               md_start;
  logic               md_done;
  logic signed [31:0] md_value;
  logic               md_sat;
  tok_t               chain [MAX_POINTS+1];
  tok_t               tok_end;

  assign slot_free    = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && slot_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign chain[0]     = launch_r;
  assign tok_end      = chain[MAX_POINTS];

  for (genvar gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
    spi_cell #(
      .MAX_POINTS(MAX_POINTS),
      .IDX       (gi)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .wr    (wr),
      .wr_idx(count_r[IDX_W-1:0]),
      .count (count_r),
      .tok_i (chain[gi]),
      .tok_o (chain[gi+1])
    );
  end

  spi_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(md_start),
    .y0   (tok_end.y0),
    .k0   (tok_end.k0),
    .y1   (tok_end.y1),
    .k1   (tok_end.k1),
    .q    (tok_end.q),
    .done (md_done),
    .value(md_value),
    .sat  (md_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_vld_r    <= 1'b0;
      launch_r.vld <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      launch_r  <= launch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_t_r <= first_t_nxt;
    first_d_r <= first_d_nxt;
    last_t_r  <= last_t_nxt;
    last_d_r  <= last_d_nxt;
    res_val_r <= res_val_nxt;
    res_sat_r <= res_sat_nxt;
    value_r   <= value_nxt;
    status_r  <= status_nxt;
    tt_r      <= tt_nxt;
    tl_r      <= tl_nxt;
    pc_r      <= pc_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    first_t_nxt = first_t_r;
    first_d_nxt = first_d_r;
    last_t_nxt  = last_t_r;
    last_d_nxt  = last_d_r;
    launch_nxt  = launch_r;
    launch_nxt.vld = 1'b0;
    res_val_nxt = res_val_r;
    res_sat_nxt = res_sat_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    value_nxt   = value_r;
    status_nxt  = status_r;
    pc_nxt      = pc_r;
    load_out    = 1'b0;
    md_start    = 1'b0;
    wr.en       = 1'b0;
    wr.distance = in_ch.point_distance;
    wr.tm       = in_ch.point_time;
    wr.vel      = in_ch.point_velocity;
    wr.acc      = in_ch.point_accel;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_out   = 1'b1;
          value_nxt  = '0;
          status_nxt = ST_OK;
          unique case (in_ch.opcode)
            OP_APPEND: begin
              if (count_r == CNT_W'(MAX_POINTS)) begin
                status_nxt = ST_FULL;
              end else begin
                wr.en      = 1'b1;
                count_nxt  = count_r + 1'b1;
                last_t_nxt = in_ch.point_time;
                last_d_nxt = in_ch.point_distance;
                if (count_r == '0) begin
                  first_t_nxt = in_ch.point_time;
                  first_d_nxt = in_ch.point_distance;
                end
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_DIST_BY_TIME, OP_VEL_BY_DIST, OP_ACC_BY_DIST, OP_TIME_BY_DIST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                load_out          = 1'b0;
                launch_nxt.vld    = 1'b1;
                launch_nxt.done   = 1'b0;
                launch_nxt.interp = 1'b0;
                launch_nxt.op     = in_ch.opcode;
                launch_nxt.q      = in_ch.query_key;
                state_nxt         = S_SCAN;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (tok_end.vld) begin
          if (tok_end.interp) begin
            md_start  = 1'b1;
            state_nxt = S_CALC;
          end else begin
            res_val_nxt = tok_end.y0;
            res_sat_nxt = 1'b0;
            state_nxt   = S_DONE;
          end
        end
      end
      S_CALC: begin
        if (md_done) begin
          res_val_nxt = md_value;
          res_sat_nxt = md_sat;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          load_out   = 1'b1;
          value_nxt  = res_val_r;
          status_nxt = res_sat_r ? ST_SAT : ST_OK;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    tt_sat = sat32({{2{last_t_nxt[31]}}, last_t_nxt} - {{2{first_t_nxt[31]}}, first_t_nxt});
    tl_sat = sat32({{2{last_d_nxt[31]}}, last_d_nxt} - {{2{first_d_nxt[31]}}, first_d_nxt});
    tt_nxt = tt_r;
    tl_nxt = tl_r;
    if (load_out) begin
      out_vld_nxt = 1'b1;
      pc_nxt      = 7'(count_nxt);
      tt_nxt      = (count_nxt == '0) ? '0 : tt_sat[31:0];
      tl_nxt      = (count_nxt == '0) ? '0 : tl_sat[31:0];
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.value        = value_r;
  assign out_ch.status       = status_r;
  assign out_ch.total_time   = tt_r;
  assign out_ch.total_length = tl_r;
  assign out_ch.point_count  = pc_r;

  `SPI_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_POINTS))
  `SPI_ASSERT_IMP(a_token_in_scan, tok_end.vld, state_r == S_SCAN)
  `SPI_ASSERT_IMP(a_div_in_calc, md_done, state_r == S_CALC)
  `SPI_ASSERT_NXT(a_accept_busy, accept, (state_r != S_IDLE) || out_vld_r)

endmodule

FILE: tb/speed_profile_interpolator_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Speed profile interpolator testbench
// Drives appends, clears, unused codes and the four lookups through the command
// channel, predicts every result from its own copy of the profile table and
// compares each result transfer field by field, under random sender and sink idling.
// ---------------------------------------------------------------------------
module speed_profile_interpolator_tb;
  import spi_pkg::*;

  localparam int NPTS = 64;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic signed [31:0] total_time;
    logic signed [31:0] total_length;
    logic [6:0]         point_count;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spi_in_if  in_ch ();
  spi_out_if out_ch ();

  speed_profile_interpolator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #6 clk = ~clk;

  logic signed [31:0] pr_dist [NPTS];
  logic signed [31:0] pr_time [NPTS];
  logic signed [31:0] pr_vel  [NPTS];
  logic signed [31:0] pr_acc  [NPTS];
  int unsigned        pr_fill;

  answer_t     pending_answers [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned queries_sent;
  bit          hold_sink;
  int unsigned gap_max;

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_APPEND;
    in_ch.point_distance = '0;
    in_ch.point_time     = '0;
    in_ch.point_velocity = '0;
    in_ch.point_accel    = '0;
    in_ch.query_key      = '0;
    out_ch.ready         = 1'b0;
  end

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                 inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] profile_lookup(input int sel,
      input logic signed [31:0] q, inout bit sat);
    logic signed [31:0] k [NPTS];
    logic signed [31:0] y [NPTS];
    int unsigned i;
    logic signed [63:0] dy, n, d, mag, quo;
    for (int j = 0; j < NPTS; j++) begin
      k[j] = (sel == OP_DIST_BY_TIME) ? pr_time[j] : pr_dist[j];
      case (sel)
        OP_DIST_BY_TIME: y[j] = pr_dist[j];
        OP_VEL_BY_DIST:  y[j] = pr_vel[j];
        OP_ACC_BY_DIST:  y[j] = pr_acc[j];
        default:         y[j] = pr_time[j];
      endcase
    end
    i = 0;
    while (i < pr_fill && k[i] < q) i++;
    if (i == 0) return y[0];
    if (i >= pr_fill) return y[pr_fill-1];
    dy  = 64'(y[i]) - 64'(y[i-1]);
    n   = 64'(q) - 64'(k[i-1]);
    d   = 64'(k[i]) - 64'(k[i-1]);
    mag = (dy < 0) ? -dy : dy;
    quo = 64'($unsigned(mag) * $unsigned(n) / $unsigned(d));
    return clamp32(64'(y[i-1]) + ((dy < 0) ? -quo : quo), sat);
  endfunction

  function automatic answer_t predict_command(input logic [2:0] op,
      input logic signed [31:0] pd, pt, pv, pa, q);
    answer_t a;
    bit sat, junk;
    a = '0;
    sat = 1'b0;
    junk = 1'b0;
    if (op == OP_APPEND) begin
      if (pr_fill >= NPTS) begin
        a.status = ST_FULL;
      end else begin
        pr_dist[pr_fill] = pd;
        pr_time[pr_fill] = pt;
        pr_vel[pr_fill]  = pv;
        pr_acc[pr_fill]  = pa;
        pr_fill++;
      end
    end else if (op == OP_CLEAR) begin
      pr_fill = 0;
    end else if (op >= OP_DIST_BY_TIME && op <= OP_TIME_BY_DIST) begin
      if (pr_fill == 0) a.status = ST_EMPTY;
      else a.value = profile_lookup(op, q, sat);
      if (sat) a.status = ST_SAT;
    end
    if (pr_fill > 0) begin
      a.total_time   = clamp32(64'(pr_time[pr_fill-1]) - 64'(pr_time[0]), junk);
      a.total_length = clamp32(64'(pr_dist[pr_fill-1]) - 64'(pr_dist[0]), junk);
    end
    a.point_count = 7'(pr_fill);
    return a;
  endfunction

  task automatic enqueue_answer(input answer_t a);
    pending_answers.insert(pending_answers.size(), a);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    mismatches++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, exp,
             results_seen);
  endtask

  task automatic send_command(input logic [2:0] op,
      input logic signed [31:0] pd, pt, pv, pa, q);
    if (gap_max > 0 && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
    enqueue_answer(predict_command(op, pd, pt, pv, pa, q));
    if (op >= OP_DIST_BY_TIME && op <= OP_TIME_BY_DIST) queries_sent++;
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.point_distance <= pd;
    in_ch.point_time     <= pt;
    in_ch.point_velocity <= pv;
    in_ch.point_accel    <= pa;
    in_ch.query_key      <= q;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic append_point(input logic signed [31:0] pd, pt, pv, pa);
    send_command(OP_APPEND, pd, pt, pv, pa, $urandom);
  endtask

  task automatic ask(input logic [2:0] op, input logic signed [31:0] q);
    send_command(op, $urandom, $urandom, $urandom, $urandom, q);
  endtask

  function automatic logic signed [31:0] random_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 600)) - 300;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      answer_t e;
      results_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result", out_ch.value, 0);
      end else begin
        e = pending_answers.pop_front();
        if (out_ch.value !== e.value)
          report_mismatch("value", out_ch.value, e.value);
        if (out_ch.status !== e.status)
          report_mismatch("status", 32'(out_ch.status), 32'(e.status));
        if (out_ch.total_time !== e.total_time)
          report_mismatch("total_time", out_ch.total_time, e.total_time);
        if (out_ch.total_length !== e.total_length)
          report_mismatch("total_length", out_ch.total_length, e.total_length);
        if (out_ch.point_count !== e.point_count)
          report_mismatch("point_count", 32'(out_ch.point_count), 32'(e.point_count));
      end
    end
  end

  // The sink stalls on its own pattern; a long hold-off is requested separately.
  always @(posedge clk) begin
    if (hold_sink) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 199) < 40) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_directed();
    ask(OP_DIST_BY_TIME, 0);
    ask(OP_TIME_BY_DIST, 32'sh7FFF_FFFF);
    append_point(32'sh0001_0000, 32'sh0002_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    ask(OP_VEL_BY_DIST, 32'sh8000_0000);
    ask(OP_ACC_BY_DIST, 32'sh7FFF_FFFF);
    append_point(32'sh0005_0000, 32'sh0006_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    append_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0001);
    ask(OP_VEL_BY_DIST, 32'sh0003_0000);
    ask(OP_ACC_BY_DIST, 32'sh0004_8000);
    ask(OP_DIST_BY_TIME, 32'sh0004_1234);
    ask(OP_TIME_BY_DIST, 32'sh4000_0000);
    ask(OP_TIME_BY_DIST, 32'sh0001_0000);
    send_command(3'd6, 1, 2, 3, 4, 5);
    send_command(3'd7, -1, -1, -1, -1, -1);
    append_point(32'sh8000_0000, 32'sh8000_0000, 5, 6);
    ask(OP_DIST_BY_TIME, 32'sh7000_0000);
    ask(OP_TIME_BY_DIST, 0);
    ask(OP_VEL_BY_DIST, 32'sh8000_0001);
    send_command(OP_CLEAR, 0, 0, 0, 0, 0);
    ask(OP_ACC_BY_DIST, 0);
  endtask

  task automatic test_full_table();
    logic signed [31:0] base;
    send_command(OP_CLEAR, 0, 0, 0, 0, 0);
    base = 32'sh8000_0000;
    for (int i = 0; i < NPTS + 3; i++) begin
      append_point(base, base + 7, random_word(), random_word());
      base = base + $urandom_range(1, 32'h0300_0000);
    end
    for (int i = 0; i < 6; i++) ask(3'($urandom_range(1, 4)), random_word());
  endtask

  task automatic build_profile(input int unsigned npts, input bit ordered);
    logic signed [31:0] d, t;
    int unsigned span;
    send_command(OP_CLEAR, 0, 0, 0, 0, 0);
    span = (npts > 1) ? 32'hFFFF_FFF0 / npts : 32'h7FFF_0000;
    d = $signed($urandom_range(0, 2000)) - 1000 - ($urandom_range(0, 1) ? 32'sh4000_0000 : 0);
    t = $signed($urandom_range(0, 2000)) - 1000;
    for (int i = 0; i < npts; i++) begin
      if (ordered) begin
        append_point(d, t, random_word(), random_word());
        d = d + $urandom_range(1, (span > 32'h0100_0000) ? 32'h0100_0000 : span);
        t = t + $urandom_range(1, 32'h0001_0000 << $urandom_range(0, 7));
      end else begin
        append_point(random_word(), random_word(), random_word(), random_word());
      end
    end
  endtask

  task automatic test_random(input int unsigned items);
    int unsigned sent, npts;
    sent = 0;
    while (sent < items) begin
      npts = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NPTS) : $urandom_range(1, 8);
      build_profile(npts, $urandom_range(0, 4) != 0);
      sent += npts + 1;
      repeat ($urandom_range(4, 14)) begin
        case ($urandom_range(0, 19))
          0: append_point(random_word(), random_word(), random_word(), random_word());
          1: send_command(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom,
                          $urandom, $urandom);
          2: ask(3'($urandom_range(1, 4)), random_word());
          default: ask(3'($urandom_range(1, 4)),
                       (pr_fill > 0) ? pr_dist[$urandom_range(0, pr_fill - 1)]
                                       + $signed($urandom_range(0, 40000)) - 20000
                                     : random_word());
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_sink = 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end
      begin
        for (int i = 0; i < 12; i++) ask(3'($urandom_range(1, 4)), random_word());
      end
    join
  endtask

  initial begin
    int unsigned guard;
    mismatches = 0;
    results_seen = 0;
    queries_sent = 0;
    hold_sink = 1'b0;
    gap_max = 0;
    pr_fill = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    gap_max = 6;
    test_full_table();
    test_backpressure();
    gap_max = 20;
    test_random(900);
    gap_max = 0;
    test_random(700);
    gap_max = 3;
    test_random(300);
    in_ch.valid <= 1'b0;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
    $display("Covered %0d results, %0d of them lookups, over empty, partial and full tables.",
             results_seen, queries_sent);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("speed_profile_interpolator_tb: done, clean");
    end else begin
      $display("speed_profile_interpolator_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Run stopped by the time limit.");
    $display("speed_profile_interpolator_tb: done, errors");
    $finish;
  end

endmodule

FILE: speed_profile_interpolator.f
+incdir+hw/rtl
hw/rtl/spi_pkg.sv
hw/rtl/spi_in_if.sv
hw/rtl/spi_out_if.sv
hw/rtl/spi_cell.sv
hw/rtl/spi_muldiv.sv
hw/rtl/speed_profile_interpolator.sv
tb/speed_profile_interpolator_tb.sv
